// ===== hdl/multi_timer_table_top_macros.svh =====
// assertion helpers for the timer table, clocked on clk and held off during rst
`ifndef MULTI_TIMER_TABLE_TOP_MACROS_SVH
`define MULTI_TIMER_TABLE_TOP_MACROS_SVH

// condition holds whenever the antecedent holds in the same cycle
`define MTT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the cycle after the antecedent
`define MTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mtt_pkg.sv =====
package mtt_pkg;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [2:0] STATUS_STARTED   = 3'd0;
  localparam logic [2:0] STATUS_FULL      = 3'd1;
  localparam logic [2:0] STATUS_FIRED     = 3'd2;
  localparam logic [2:0] STATUS_DONE      = 3'd3;
  localparam logic [2:0] STATUS_CLEARED   = 3'd4;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd5;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] elapsed;
    logic [31:0] duration;
    logic        repeat_req;
    logic [31:0] clear_key;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] timer_key;
    logic        last;
  } result_t;

  typedef struct packed {
    logic        rpt;
    logic [31:0] duration;
    logic [31:0] count;
    logic [31:0] key;
  } entry_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        fire;
    logic        key_hit;
  } unit_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FINISH
  } state_t;

endpackage

// ===== hdl/mtt_store.sv =====
module mtt_store #(
  parameter int NUM_TIMERS = 16,
  parameter int IDX_W      = 4
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  mtt_pkg::entry_t      wr_data,
  output mtt_pkg::entry_t      rdata
);

  mtt_pkg::entry_t mem [NUM_TIMERS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/mtt_unit.sv =====
module mtt_unit (
  input  logic [31:0]        count,
  input  logic [31:0]        elapsed,
  input  logic [31:0]        duration,
  input  logic [31:0]        entry_key,
  input  logic [31:0]        clear_key,
  output mtt_pkg::unit_res_t res
);

  logic [32:0] total;

  assign total = {1'b0, count} + {1'b0, elapsed};

  always_comb begin
    // saturate on carry out
    res.sum     = total[32] ? mtt_pkg::COUNT_MAX : total[31:0];
    res.fire    = res.sum >= duration;
    res.key_hit = entry_key == clear_key;
  end

endmodule

// ===== hdl/mtt_seq.sv =====
module mtt_seq #(
  parameter int NUM_TIMERS = 16,
  parameter int IDX_W      = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  mtt_pkg::item_t     item,
  output logic               result_valid,
  input  logic               result_ready,
  output mtt_pkg::result_t   result,
  output mtt_pkg::item_t     op,
  output logic               rd_en,
  output logic [IDX_W-1:0]   rd_addr,
  output logic               wr_en,
  output logic [IDX_W-1:0]   wr_addr,
  output mtt_pkg::entry_t    wr_data,
  input  mtt_pkg::entry_t    rdata,
  input  mtt_pkg::unit_res_t unit_res
);

  mtt_pkg::state_t state, state_next;
  logic [IDX_W-1:0]      idx;
  logic [NUM_TIMERS-1:0] valid_q;
  logic [NUM_TIMERS-1:0] expired_q;
  logic [31:0]           key_counter;
  logic [31:0]           key_inc;

  logic             accept;
  logic             out_free;
  logic             last_slot;
  logic             slot_v;
  logic             slot_x;
  logic             step_done;
  logic             step_end;
  logic             emit;
  mtt_pkg::result_t emit_res;
  logic             set_valid;
  logic             clr_valid;
  logic             set_exp;
  logic             clr_exp;
  logic             key_bump;

  assign item_ready = state == mtt_pkg::S_IDLE;
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;
  assign last_slot  = idx == IDX_W'(NUM_TIMERS - 1);
  assign slot_v     = valid_q[idx];
  assign slot_x     = expired_q[idx];
  assign key_inc    = key_counter + 32'd1;
  assign wr_addr    = idx;

  // read one slot ahead so the next slot's entry is ready when the sweep moves on
  assign rd_en   = accept || (step_done && !last_slot);
  assign rd_addr = accept ? '0 : idx + 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      mtt_pkg::S_IDLE: begin
        if (accept && item.kind != mtt_pkg::KIND_NONE) state_next = mtt_pkg::S_SWEEP;
      end
      mtt_pkg::S_SWEEP: begin
        if (step_end) state_next = mtt_pkg::S_IDLE;
        else if (step_done && last_slot) state_next = mtt_pkg::S_FINISH;
      end
      mtt_pkg::S_FINISH: begin
        if (step_end) state_next = mtt_pkg::S_IDLE;
      end
      default: state_next = mtt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    step_done = 1'b0;
    step_end  = 1'b0;
    emit      = 1'b0;
    emit_res  = '0;
    wr_en     = 1'b0;
    wr_data   = rdata;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    set_exp   = 1'b0;
    clr_exp   = 1'b0;
    key_bump  = 1'b0;
    unique case (state)
      mtt_pkg::S_SWEEP: begin
        case (op.kind)
          mtt_pkg::KIND_TICK: begin
            if (!slot_v) begin
              step_done = 1'b1;
            end else if (slot_x) begin
              clr_valid = 1'b1;
              step_done = 1'b1;
            end else if (!unit_res.fire) begin
              wr_en         = 1'b1;
              wr_data.count = unit_res.sum;
              step_done     = 1'b1;
            end else if (out_free) begin
              emit               = 1'b1;
              emit_res.status    = mtt_pkg::STATUS_FIRED;
              emit_res.slot      = 4'(idx);
              emit_res.timer_key = rdata.key;
              emit_res.last      = 1'b0;
              wr_en              = 1'b1;
              wr_data.count      = rdata.rpt ? '0 : unit_res.sum;
              set_exp            = !rdata.rpt;
              step_done          = 1'b1;
            end
          end
          mtt_pkg::KIND_START: begin
            if (slot_v) begin
              step_done = 1'b1;
            end else if (out_free) begin
              emit               = 1'b1;
              emit_res.status    = mtt_pkg::STATUS_STARTED;
              emit_res.slot      = 4'(idx);
              emit_res.timer_key = key_inc;
              emit_res.last      = 1'b1;
              wr_en              = 1'b1;
              wr_data.rpt        = op.repeat_req;
              wr_data.duration   = op.duration;
              wr_data.count      = '0;
              wr_data.key        = key_inc;
              set_valid          = 1'b1;
              clr_exp            = 1'b1;
              key_bump           = 1'b1;
              step_end           = 1'b1;
            end
          end
          mtt_pkg::KIND_CLEAR: begin
            if (slot_v && unit_res.key_hit) begin
              if (out_free) begin
                emit               = 1'b1;
                emit_res.status    = mtt_pkg::STATUS_CLEARED;
                emit_res.slot      = 4'(idx);
                emit_res.timer_key = op.clear_key;
                emit_res.last      = 1'b1;
                set_exp            = 1'b1;
                step_end           = 1'b1;
              end
            end else begin
              step_done = 1'b1;
            end
          end
          default: step_end = 1'b1;
        endcase
      end
      mtt_pkg::S_FINISH: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_res.last = 1'b1;
          case (op.kind)
            mtt_pkg::KIND_TICK:  emit_res.status = mtt_pkg::STATUS_DONE;
            mtt_pkg::KIND_START: emit_res.status = mtt_pkg::STATUS_FULL;
            default:             emit_res.status = mtt_pkg::STATUS_NOT_FOUND;
          endcase
          step_end = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mtt_pkg::S_IDLE;
      idx          <= '0;
      valid_q      <= '0;
      expired_q    <= '0;
      key_counter  <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        idx <= '0;
      end else if (step_done && !last_slot) begin
        idx <= idx + 1'b1;
      end
      if (set_valid) valid_q[idx] <= 1'b1;
      if (clr_valid) valid_q[idx] <= 1'b0;
      if (set_exp) expired_q[idx] <= 1'b1;
      if (clr_exp) expired_q[idx] <= 1'b0;
      if (key_bump) key_counter <= key_inc;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) op <= item;
    if (emit) result <= emit_res;
  end

endmodule

// ===== hdl/multi_timer_table_top.sv =====
// Table of NUM_TIMERS software timers. Start takes the lowest free slot and returns a new key
// (or table full), clear marks the timer with a matching key as expired, and tick frees
// expired slots, advances every live count by the elapsed time (saturating; a repeating
// timer that fires restarts from zero), and emits one fire beat per timer that reaches its
// duration, followed by a done beat with last set. Items are handled one at a time: after
// the accept cycle, a sweep visits one slot per cycle through the single read port of the
// entry memory, except where a beat must wait for the result side. Start and clear end at
// the slot that matches, or sweep every slot when none does; a tick always sweeps every slot.
// A kind-three item is taken and dropped with no result. Result beats sit in an output
// register, so a new item can be accepted while the last beat is still waiting.
`include "multi_timer_table_top_macros.svh"

module multi_timer_table_top #(
  parameter int NUM_TIMERS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  mtt_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output mtt_pkg::result_t result
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  mtt_pkg::item_t     op;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  mtt_pkg::entry_t    wr_data;
  mtt_pkg::entry_t    rdata;
  mtt_pkg::unit_res_t unit_res;

  mtt_store #(
    .NUM_TIMERS(NUM_TIMERS),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rdata  (rdata)
  );

  mtt_unit u_unit (
    .count    (rdata.count),
    .elapsed  (op.elapsed),
    .duration (rdata.duration),
    .entry_key(rdata.key),
    .clear_key(op.clear_key),
    .res      (unit_res)
  );

  mtt_seq #(
    .NUM_TIMERS(NUM_TIMERS),
    .IDX_W     (IDX_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .op          (op),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rdata       (rdata),
    .unit_res    (unit_res)
  );

  `MTT_ASSERT_NEXT(a_busy_after_accept,
    item_valid && item_ready && item.kind != mtt_pkg::KIND_NONE, !item_ready,
    "ready still high after a working item was taken")
  `MTT_ASSERT_IMPL(a_mid_beat_is_fire,
    result_valid && !result.last, result.status == mtt_pkg::STATUS_FIRED,
    "non-final beat that is not a fire event")
  `MTT_ASSERT_IMPL(a_no_rw_clash,
    wr_en && rd_en, wr_addr != rd_addr,
    "entry read and written at the same slot")
  `MTT_ASSERT_IMPL(a_done_beat_empty,
    result_valid && result.status == mtt_pkg::STATUS_DONE,
    result.last && result.slot == '0 && result.timer_key == '0,
    "malformed done beat")

endmodule
